// File: hdl/kst_pkg.sv
// ----------------------------------------------------------------------------
// kst_pkg: shared types and constants for the keyed sum table.
// Holds the controller commands and status, the state type and defaults.
// ----------------------------------------------------------------------------
`default_nettype none
package kst_pkg;

   localparam int TableEntriesDefault = 32;
   localparam int KeyBytesDefault     = 16;

   localparam logic [1:0] KIND_ADD    = 2'd0;
   localparam logic [1:0] KIND_DAYS   = 2'd1;
   localparam logic [1:0] KIND_FINISH = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_UPDATE,
      ST_SCAN,
      ST_EMIT,
      ST_WAIT
   } state_type;

   typedef struct packed {
      logic capture;
      logic search_start;
      logic search_step;
      logic update;
      logic scan_start;
      logic scan_step;
      logic emit_load;
      logic clear;
   } cmd_type;

   typedef struct packed {
      logic search_done;
      logic scan_done;
      logic table_empty;
      logic more_rows;
   } sts_type;

endpackage
`default_nettype wire

// File: hdl/kst_ctrl.sv
// ----------------------------------------------------------------------------
// kst_ctrl: controller for the keyed sum table.
// Sequences key search, entry update and the sorted dump.
// ----------------------------------------------------------------------------
`default_nettype none
module kst_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire logic [1:0]      req_kind,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output kst_pkg::cmd_type     cmd,
   input  wire kst_pkg::sts_type sts
);
   import kst_pkg::*;

   state_type state_ff, state_in;
   logic      take;

   assign take = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               if (req_kind == KIND_ADD) begin
                  state_in = ST_SEARCH;
               end else if (req_kind == KIND_FINISH) begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SEARCH: begin
            if (sts.search_done) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: state_in = ST_IDLE;
         ST_SCAN: begin
            if (sts.scan_done || sts.table_empty) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: state_in = ST_WAIT;
         ST_WAIT: begin
            if (rsp_ready) begin
               state_in = sts.more_rows ? ST_SCAN : ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready         = 1'b1;
            cmd.capture       = take;
            cmd.search_start  = take && (req_kind == KIND_ADD);
            cmd.scan_start    = take && (req_kind == KIND_FINISH);
         end
         ST_SEARCH: cmd.search_step = 1'b1;
         ST_UPDATE: cmd.update = 1'b1;
         ST_SCAN:   cmd.scan_step = 1'b1;
         ST_EMIT:   cmd.emit_load = 1'b1;
         ST_WAIT: begin
            rsp_valid  = 1'b1;
            cmd.clear  = rsp_ready && !sts.more_rows;
            cmd.scan_start = rsp_ready && sts.more_rows;
         end
         default: ;
      endcase
   end
endmodule
`default_nettype wire

// File: hdl/kst_dp.sv
// ----------------------------------------------------------------------------
// kst_dp: datapath of the keyed sum table.
// Entry memories, linear key search and a selection scan for the dump.
// ----------------------------------------------------------------------------
`default_nettype none
module kst_dp #(
   parameter int TABLE_ENTRIES = kst_pkg::TableEntriesDefault,
   parameter int KEY_BYTES     = kst_pkg::KeyBytesDefault
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire kst_pkg::cmd_type cmd,
   output kst_pkg::sts_type      sts,
   input  wire logic [1:0]       req_kind,
   input  wire logic [63:0]      req_key_high,
   input  wire logic [63:0]      req_key_low,
   input  wire logic [63:0]      req_add_tokens,
   input  wire logic [63:0]      req_add_cents,
   input  wire logic [31:0]      req_add_sessions,
   input  wire logic [31:0]      req_add_messages,
   input  wire logic [15:0]      req_host_days,
   output logic [63:0]           rsp_out_key_high,
   output logic [63:0]           rsp_out_key_low,
   output logic [63:0]           rsp_out_tokens,
   output logic [63:0]           rsp_out_cents,
   output logic [31:0]           rsp_out_sessions,
   output logic [31:0]           rsp_out_messages,
   output logic [63:0]           rsp_grand_tokens,
   output logic [15:0]           rsp_most_days,
   output logic                  rsp_any_present,
   output logic                  rsp_row_valid,
   output logic                  rsp_last
);
   import kst_pkg::*;

   localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CW = $clog2(TABLE_ENTRIES + 1);
   localparam logic [CW-1:0] FULL = CW'(TABLE_ENTRIES);

   logic [63:0] key_high_mem [TABLE_ENTRIES];
   logic [63:0] key_low_mem  [TABLE_ENTRIES];
   logic [63:0] tokens_mem   [TABLE_ENTRIES];
   logic [63:0] cents_mem    [TABLE_ENTRIES];
   logic [31:0] sessions_mem [TABLE_ENTRIES];
   logic [31:0] messages_mem [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] done_ff;

   logic [CW-1:0] count_ff;
   logic [63:0]   total_ff;
   logic [15:0]   days_ff;
   logic          seen_ff;

   logic [63:0] kh_ff, kl_ff, tok_ff, cen_ff;
   logic [31:0] ses_ff, msg_ff;
   logic [CW-1:0] ptr_ff;
   logic          hit_ff;
   logic [IW-1:0] hit_idx_ff;

   logic [63:0] rd_kh_ff, rd_kl_ff, rd_tok_ff, rd_cen_ff;
   logic [31:0] rd_ses_ff, rd_msg_ff;
   logic        rd_ok_ff;
   logic [IW-1:0] rd_idx_ff;

   logic          best_ok_ff;
   logic [IW-1:0] best_idx_ff;
   logic [63:0]   best_tok_ff;
   logic [CW-1:0] emitted_ff;

   logic [127:0] key_raw;
   logic [127:0] canon;
   logic [IW-1:0] ptr_idx;
   logic          ptr_live;

   assign key_raw = {req_key_high, req_key_low};

   always_comb begin
      logic ended;
      logic [7:0] b;
      ended = 1'b0;
      canon = '0;
      for (int i = 0; i < 16; i++) begin
         b = key_raw[127 - 8*i -: 8];
         if (i >= KEY_BYTES || b == 8'd0) begin
            ended = 1'b1;
         end
         canon[127 - 8*i -: 8] = ended ? 8'd0 : b;
      end
   end

   assign ptr_idx  = ptr_ff[IW-1:0];
   assign ptr_live = ptr_ff < count_ff;

   function automatic logic [63:0] sat64(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? '1 : s[63:0];
   endfunction

   function automatic logic [31:0] sat32(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? '1 : s[31:0];
   endfunction

   // Memory read port: one entry per cycle, registered.
   always_ff @(posedge clock) begin
      rd_kh_ff  <= key_high_mem[ptr_idx];
      rd_kl_ff  <= key_low_mem[ptr_idx];
      rd_tok_ff <= tokens_mem[ptr_idx];
      rd_cen_ff <= cents_mem[ptr_idx];
      rd_ses_ff <= sessions_mem[ptr_idx];
      rd_msg_ff <= messages_mem[ptr_idx];
      rd_idx_ff <= ptr_idx;
   end

   logic [IW-1:0] wr_idx;
   logic          do_write;
   assign wr_idx   = hit_ff ? hit_idx_ff : count_ff[IW-1:0];
   assign do_write = cmd.update && (hit_ff || count_ff < FULL);

   always_ff @(posedge clock) begin
      if (do_write) begin
         key_high_mem[wr_idx] <= kh_ff;
         key_low_mem[wr_idx]  <= kl_ff;
         tokens_mem[wr_idx]   <= hit_ff ? sat64(rd_tok_ff, tok_ff) : tok_ff;
         cents_mem[wr_idx]    <= hit_ff ? sat64(rd_cen_ff, cen_ff) : cen_ff;
         sessions_mem[wr_idx] <= hit_ff ? sat32(rd_ses_ff, ses_ff) : ses_ff;
         messages_mem[wr_idx] <= hit_ff ? sat32(rd_msg_ff, msg_ff) : msg_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kh_ff  <= canon[127:64];
         kl_ff  <= canon[63:0];
         tok_ff <= req_add_tokens;
         cen_ff <= req_add_cents;
         ses_ff <= req_add_sessions;
         msg_ff <= req_add_messages;
      end
   end

   // Search and scan both walk ptr_ff; rd_ok_ff marks a read in flight.
   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff <= '0;
         rd_ok_ff <= 1'b0;
         hit_ff <= 1'b0;
         hit_idx_ff <= '0;
         best_ok_ff <= 1'b0;
         best_idx_ff <= '0;
         best_tok_ff <= '0;
      end else if (cmd.search_start || cmd.scan_start) begin
         ptr_ff <= '0;
         rd_ok_ff <= 1'b0;
         hit_ff <= 1'b0;
         best_ok_ff <= 1'b0;
      end else if (cmd.search_step) begin
         rd_ok_ff <= ptr_live && !hit_ff;
         if (ptr_live && !hit_ff) begin
            ptr_ff <= ptr_ff + 1'b1;
         end
         if (rd_ok_ff && !hit_ff && rd_kh_ff == kh_ff && rd_kl_ff == kl_ff) begin
            hit_ff <= 1'b1;
            hit_idx_ff <= rd_idx_ff;
            ptr_ff <= CW'(rd_idx_ff);
            rd_ok_ff <= 1'b0;
         end
      end else if (cmd.scan_step) begin
         rd_ok_ff <= ptr_live;
         if (ptr_live) begin
            ptr_ff <= ptr_ff + 1'b1;
         end
         if (rd_ok_ff && !done_ff[rd_idx_ff] &&
             (!best_ok_ff || rd_tok_ff > best_tok_ff)) begin
            best_ok_ff <= 1'b1;
            best_idx_ff <= rd_idx_ff;
            best_tok_ff <= rd_tok_ff;
         end
      end else if (cmd.emit_load) begin
         ptr_ff <= CW'(best_idx_ff);
      end
   end

   always_comb begin
      sts = '0;
      // Search ends once no read is pending and either a hit or the end.
      sts.search_done = !rd_ok_ff && (hit_ff ? (ptr_ff == CW'(hit_idx_ff)) : !ptr_live)
                        && !cmd.search_start;
      sts.scan_done   = !rd_ok_ff && !ptr_live;
      sts.table_empty = count_ff == '0;
      sts.more_rows   = emitted_ff < count_ff;
   end

   // The hit read address is reloaded so rd_*_ff holds the hit entry.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         total_ff   <= '0;
         days_ff    <= '0;
         seen_ff    <= 1'b0;
         done_ff    <= '0;
         emitted_ff <= '0;
      end else begin
         if (cmd.capture && req_kind == KIND_ADD) begin
            seen_ff <= 1'b1;
         end
         if (cmd.capture && req_kind == KIND_DAYS && req_host_days > days_ff) begin
            days_ff <= req_host_days;
         end
         if (do_write) begin
            total_ff <= sat64(total_ff, tok_ff);
            if (!hit_ff) begin
               count_ff <= count_ff + 1'b1;
            end
         end
         if (cmd.emit_load && count_ff != '0) begin
            done_ff[best_idx_ff] <= 1'b1;
            emitted_ff <= emitted_ff + 1'b1;
         end
         if (cmd.clear) begin
            count_ff   <= '0;
            total_ff   <= '0;
            days_ff    <= '0;
            seen_ff    <= 1'b0;
            done_ff    <= '0;
            emitted_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_load) begin
         rsp_out_key_high <= (count_ff == '0) ? '0 : key_high_mem[best_idx_ff];
         rsp_out_key_low  <= (count_ff == '0) ? '0 : key_low_mem[best_idx_ff];
         rsp_out_tokens   <= (count_ff == '0) ? '0 : tokens_mem[best_idx_ff];
         rsp_out_cents    <= (count_ff == '0) ? '0 : cents_mem[best_idx_ff];
         rsp_out_sessions <= (count_ff == '0) ? '0 : sessions_mem[best_idx_ff];
         rsp_out_messages <= (count_ff == '0) ? '0 : messages_mem[best_idx_ff];
         rsp_grand_tokens <= total_ff;
         rsp_most_days    <= days_ff;
         rsp_any_present  <= seen_ff;
         rsp_row_valid    <= count_ff != '0;
         rsp_last         <= (count_ff == '0) || (emitted_ff + 1'b1 == count_ff);
      end
   end
endmodule
`default_nettype wire

// File: hdl/keyed_sum_table_sorted_dump_core.sv
// ----------------------------------------------------------------------------
// keyed_sum_table_sorted_dump_core: group-by sum table with sorted dump.
// An add row runs the key search over the stored entries, then the entry
// update, before the next accept. A days report is taken while idle.
// A finish gives each result after a selection scan over the entry
// memory; each result is held until rsp_ready before the next scan.
// Synchronous active-high reset empties the table and clears all totals.
// ----------------------------------------------------------------------------
`default_nettype none
module keyed_sum_table_sorted_dump_core #(
   parameter int TABLE_ENTRIES = kst_pkg::TableEntriesDefault,
   parameter int KEY_BYTES     = kst_pkg::KeyBytesDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_kind,
   input  wire logic [63:0] req_key_high,
   input  wire logic [63:0] req_key_low,
   input  wire logic [63:0] req_add_tokens,
   input  wire logic [63:0] req_add_cents,
   input  wire logic [31:0] req_add_sessions,
   input  wire logic [31:0] req_add_messages,
   input  wire logic [15:0] req_host_days,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [63:0]      rsp_out_key_high,
   output logic [63:0]      rsp_out_key_low,
   output logic [63:0]      rsp_out_tokens,
   output logic [63:0]      rsp_out_cents,
   output logic [31:0]      rsp_out_sessions,
   output logic [31:0]      rsp_out_messages,
   output logic [63:0]      rsp_grand_tokens,
   output logic [15:0]      rsp_most_days,
   output logic             rsp_any_present,
   output logic             rsp_row_valid,
   output logic             rsp_last
);
   import kst_pkg::*;

   cmd_type cmd;
   sts_type sts;

   kst_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .req_kind,
      .rsp_valid, .rsp_ready, .cmd, .sts
   );

   kst_dp #(.TABLE_ENTRIES(TABLE_ENTRIES), .KEY_BYTES(KEY_BYTES)) u_dp (
      .clock, .reset, .cmd, .sts, .req_kind, .req_key_high, .req_key_low,
      .req_add_tokens, .req_add_cents, .req_add_sessions, .req_add_messages,
      .req_host_days, .rsp_out_key_high, .rsp_out_key_low, .rsp_out_tokens,
      .rsp_out_cents, .rsp_out_sessions, .rsp_out_messages, .rsp_grand_tokens,
      .rsp_most_days, .rsp_any_present, .rsp_row_valid, .rsp_last
   );
endmodule
`default_nettype wire
